// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the detector RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PFBD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pfbd check failed");

// Next-cycle implication, disabled during reset.
`define PFBD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pfbd check failed");

`endif

// ===== rtl/pfbd_pkg.sv =====
// Package for the pulse frequency band detector: widths, register codes,
// reset values and the structs passed between the front, queue and back.
package pfbd_pkg;

   localparam int WINDOW_W   = 24;
   localparam int COUNT_W    = 16;
   localparam int ACC_W      = 32;
   localparam int DUTY_W     = 8;
   localparam int PROD_W     = ACC_W + 7;      // sum * 100
   localparam int DVS_W      = WINDOW_W + DUTY_W;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [3:0] DIV_LAST_STEP = 4'd8;   // quotient bits 8..0

   localparam logic [CSR_IDX_W-1:0] REG_WINDOW_TICKS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MIN_COUNT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_COUNT    = 2'd2;

   localparam logic [WINDOW_W-1:0] WINDOW_RESET = 24'd100000;
   localparam logic [COUNT_W-1:0]  MIN_RESET    = 16'd80;
   localparam logic [COUNT_W-1:0]  MAX_RESET    = 16'd200;
   localparam logic [DUTY_W-1:0]   DUTY_MAX     = 8'd255;

   typedef struct packed {
      logic [WINDOW_W-1:0] span;       // window length, zero mapped to one
      logic [COUNT_W-1:0]  min_count;
      logic [COUNT_W-1:0]  max_count;
   } pfbd_cfg_type;

   typedef struct packed {
      logic               close;       // this tick closes a window
      logic               hit;         // edge count in band
      logic [COUNT_W-1:0] tally;
      logic [ACC_W-1:0]   sum;
   } pfbd_entry_type;

endpackage

// ===== rtl/pfbd_if.sv =====
// Handshake channel interfaces for the detector: sample input, result
// output and register write port. Depends on pfbd_pkg.
interface pfbd_req_if;
   logic valid;
   logic ready;
   logic line_level;
   modport source (output valid, output line_level, input ready);
   modport sink   (input valid, input line_level, output ready);
endinterface

interface pfbd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          detected;
   logic [pfbd_pkg::DUTY_W-1:0]   duty_percent;
   logic [pfbd_pkg::COUNT_W-1:0]  window_edge_count;
   logic                          window_done;
   modport source (output valid, output detected, output duty_percent,
                   output window_edge_count, output window_done, input ready);
   modport sink   (input valid, input detected, input duty_percent,
                   input window_edge_count, input window_done, output ready);
endinterface

interface pfbd_csr_if;
   logic                             valid;
   logic                             ready;
   logic [pfbd_pkg::CSR_IDX_W-1:0]   index;
   logic [pfbd_pkg::CSR_DATA_W-1:0]  data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/pulse_frequency_band_detector_unit.sv =====
// Top level of the pulse frequency band detector: register file, front end,
// entry queue and back end. Uses pfbd_pkg, pfbd_if and the pfbd_* modules.
//
//   channel   dir  payload
//   req_chan  in   line_level
//   rsp_chan  out  detected, duty_percent, window_edge_count, window_done
//   csr_chan  in   index, data (window_ticks, min_count, max_count)
//
// One sample per cycle; each entry goes into the queue and is popped by the
// back end, which loads its result into the output register. A window that
// closes with its edge count in band holds the back end for a pop, 9 restoring
// division steps and the result load. The 4-entry queue takes up to four
// samples meanwhile; the front stalls only when the queue is full. Reset is
// synchronous: all counts clear and the registers return to 100000 / 80 / 200.
module pulse_frequency_band_detector_unit (
   input  logic      clock,
   input  logic      reset,
   pfbd_req_if.sink  req_chan,
   pfbd_rsp_if.source rsp_chan,
   pfbd_csr_if.sink  csr_chan
);

   logic [pfbd_pkg::WINDOW_W-1:0] window_ff;
   logic [pfbd_pkg::COUNT_W-1:0]  min_ff;
   logic [pfbd_pkg::COUNT_W-1:0]  max_ff;

   pfbd_pkg::pfbd_cfg_type   cfg;
   pfbd_pkg::pfbd_entry_type push_entry;
   pfbd_pkg::pfbd_entry_type head;
   logic                     push, pop, full, not_empty;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= pfbd_pkg::WINDOW_RESET;
         min_ff    <= pfbd_pkg::MIN_RESET;
         max_ff    <= pfbd_pkg::MAX_RESET;
      end else if (csr_chan.valid) begin
         case (csr_chan.index)
            pfbd_pkg::REG_WINDOW_TICKS: window_ff <= csr_chan.data;
            pfbd_pkg::REG_MIN_COUNT:    min_ff    <= csr_chan.data[pfbd_pkg::COUNT_W-1:0];
            pfbd_pkg::REG_MAX_COUNT:    max_ff    <= csr_chan.data[pfbd_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // zero-length window behaves as one tick
   assign cfg.span      = (window_ff == '0) ? pfbd_pkg::WINDOW_W'(1) : window_ff;
   assign cfg.min_count = min_ff;
   assign cfg.max_count = max_ff;

   pfbd_front u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_chan),
      .cfg     (cfg),
      .q_full  (full),
      .q_push  (push),
      .q_entry (push_entry)
   );

   pfbd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (full),
      .not_empty  (not_empty),
      .head       (head)
   );

   pfbd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .q_not_empty (not_empty),
      .q_head      (head),
      .q_pop       (pop),
      .rsp         (rsp_chan)
   );

endmodule

// ===== rtl/pfbd_front.sv =====
// Front end: takes one sample per transfer, tracks edges, high runs and the
// gating window, and pushes one classified entry per sample. Uses pfbd_pkg.
module pfbd_front (
   input  logic                    clock,
   input  logic                    reset,
   pfbd_req_if.sink                req,
   input  pfbd_pkg::pfbd_cfg_type  cfg,
   input  logic                    q_full,
   output logic                    q_push,
   output pfbd_pkg::pfbd_entry_type q_entry
);

   logic                         prev_ff, prev_in;
   logic [pfbd_pkg::WINDOW_W-1:0] pos_ff, pos_in;
   logic [pfbd_pkg::COUNT_W-1:0]  tally_ff, tally_in;
   logic [pfbd_pkg::ACC_W-1:0]    run_ff, run_in;
   logic [pfbd_pkg::ACC_W-1:0]    sum_ff, sum_in;

   logic [pfbd_pkg::COUNT_W-1:0]  tally_upd;
   logic [pfbd_pkg::ACC_W-1:0]    sum_upd;
   logic [pfbd_pkg::ACC_W:0]      sum_wide;
   logic [pfbd_pkg::WINDOW_W:0]   pos_inc;
   logic                         close;
   logic                         accept;

   assign req.ready = !q_full;
   assign accept    = req.valid && !q_full;

   always_comb begin
      run_in    = run_ff;
      tally_upd = tally_ff;
      sum_upd   = sum_ff;
      sum_wide  = {1'b0, sum_ff} + {1'b0, run_ff};
      if (req.line_level && !prev_ff) begin
         run_in = {{(pfbd_pkg::ACC_W-1){1'b0}}, 1'b1};
      end else if (req.line_level) begin
         if (run_ff != {pfbd_pkg::ACC_W{1'b1}}) run_in = run_ff + 1'b1;
      end else if (prev_ff) begin
         // falling edge: count it and bank the run length
         if (tally_ff != {pfbd_pkg::COUNT_W{1'b1}}) tally_upd = tally_ff + 1'b1;
         sum_upd = sum_wide[pfbd_pkg::ACC_W] ? {pfbd_pkg::ACC_W{1'b1}}
                                             : sum_wide[pfbd_pkg::ACC_W-1:0];
      end

      pos_inc = {1'b0, pos_ff} + 1'b1;
      close   = pos_inc >= {1'b0, cfg.span};

      q_entry.close = close;
      q_entry.hit   = (tally_upd >= cfg.min_count) && (tally_upd <= cfg.max_count);
      q_entry.tally = tally_upd;
      q_entry.sum   = sum_upd;

      prev_in  = req.line_level;
      pos_in   = close ? '0 : pos_inc[pfbd_pkg::WINDOW_W-1:0];
      tally_in = close ? '0 : tally_upd;
      sum_in   = close ? '0 : sum_upd;
   end

   assign q_push = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= 1'b0;
         pos_ff   <= '0;
         tally_ff <= '0;
         run_ff   <= '0;
         sum_ff   <= '0;
      end else if (accept) begin
         prev_ff  <= prev_in;
         pos_ff   <= pos_in;
         tally_ff <= tally_in;
         run_ff   <= run_in;
         sum_ff   <= sum_in;
      end
   end

endmodule

// ===== rtl/pfbd_queue.sv =====
// Short FIFO of classified entries between front and back.
// Uses pfbd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pfbd_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  pfbd_pkg::pfbd_entry_type push_entry,
   input  logic                     pop,
   output logic                     full,
   output logic                     not_empty,
   output pfbd_pkg::pfbd_entry_type head
);

   pfbd_pkg::pfbd_entry_type       slot_ff [pfbd_pkg::QUEUE_DEPTH];
   logic [pfbd_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [pfbd_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [pfbd_pkg::QCNT_W-1:0]    count_ff, count_in;

   localparam logic [pfbd_pkg::QCNT_W-1:0] DEPTH_CNT =
      pfbd_pkg::QCNT_W'(pfbd_pkg::QUEUE_DEPTH);
   localparam logic [pfbd_pkg::QPTR_W-1:0] LAST_PTR =
      pfbd_pkg::QPTR_W'(pfbd_pkg::QUEUE_DEPTH - 1);

   assign full      = count_ff == DEPTH_CNT;
   assign not_empty = count_ff != '0;
   assign head      = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)  rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop)      count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_entry;
   end

   `PFBD_ASSERT_IMP(a_no_push_full, clock, reset, push, !full)
   `PFBD_ASSERT_IMP(a_no_pop_empty, clock, reset, pop, not_empty)

endmodule

// ===== rtl/pfbd_back.sv =====
// Back end: pops entries, keeps the held verdict, duty and edge count, runs
// the duty division one quotient bit per cycle and drives the result
// register. Uses pfbd_pkg and assert_macros.svh.
`include "assert_macros.svh"

module pfbd_back (
   input  logic                     clock,
   input  logic                     reset,
   input  pfbd_pkg::pfbd_cfg_type   cfg,
   input  logic                     q_not_empty,
   input  pfbd_pkg::pfbd_entry_type q_head,
   output logic                     q_pop,
   pfbd_rsp_if.source               rsp
);

   typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_EMIT} state_type;

   state_type                     state_ff, state_in;
   logic                          held_det_ff, held_det_in;
   logic [pfbd_pkg::DUTY_W-1:0]   held_duty_ff, held_duty_in;
   logic [pfbd_pkg::COUNT_W-1:0]  held_tally_ff, held_tally_in;
   logic [pfbd_pkg::PROD_W-1:0]   rem_ff, rem_in;
   logic [pfbd_pkg::DVS_W-1:0]    dvs_ff, dvs_in;
   logic [pfbd_pkg::DUTY_W:0]     quo_ff, quo_in;
   logic [3:0]                    step_ff, step_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_det_ff, rsp_det_in;
   logic [pfbd_pkg::DUTY_W-1:0]   rsp_duty_ff, rsp_duty_in;
   logic [pfbd_pkg::COUNT_W-1:0]  rsp_tally_ff, rsp_tally_in;
   logic                          rsp_done_ff, rsp_done_in;

   logic                          slot_free;
   logic                          ge;
   logic [pfbd_pkg::PROD_W-1:0]   prod;
   logic [pfbd_pkg::PROD_W-1:0]   dvs_wide;

   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign q_pop     = (state_ff == ST_IDLE) && q_not_empty && slot_free;

   // sum * 100 as 64 + 32 + 4
   assign prod = {1'b0, q_head.sum, 6'b0} + {2'b0, q_head.sum, 5'b0}
               + {5'b0, q_head.sum, 2'b0};
   assign dvs_wide = {{(pfbd_pkg::PROD_W-pfbd_pkg::DVS_W){1'b0}}, dvs_ff};
   assign ge       = rem_ff >= dvs_wide;

   always_comb begin
      state_in      = state_ff;
      held_det_in   = held_det_ff;
      held_duty_in  = held_duty_ff;
      held_tally_in = held_tally_ff;
      rem_in        = rem_ff;
      dvs_in        = dvs_ff;
      quo_in        = quo_ff;
      step_in       = step_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_det_in    = rsp_det_ff;
      rsp_duty_in   = rsp_duty_ff;
      rsp_tally_in  = rsp_tally_ff;
      rsp_done_in   = rsp_done_ff;

      case (state_ff)
         ST_IDLE: begin
            if (q_pop) begin
               if (q_head.close) begin
                  held_det_in   = q_head.hit;
                  held_tally_in = q_head.tally;
               end
               if (q_head.close && q_head.hit) begin
                  rem_in   = prod;
                  dvs_in   = {cfg.span, {pfbd_pkg::DUTY_W{1'b0}}};
                  quo_in   = '0;
                  step_in  = pfbd_pkg::DIV_LAST_STEP;
                  state_in = ST_DIV;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_det_in   = held_det_in;
                  rsp_duty_in  = held_duty_ff;
                  rsp_tally_in = held_tally_in;
                  rsp_done_in  = q_head.close;
               end
            end
         end
         ST_DIV: begin
            // restoring step; the top quotient bit flags saturation
            if (ge) rem_in = rem_ff - dvs_wide;
            dvs_in = dvs_ff >> 1;
            quo_in = {quo_ff[pfbd_pkg::DUTY_W-1:0], ge};
            if (step_ff == '0) begin
               held_duty_in = quo_in[pfbd_pkg::DUTY_W] ? pfbd_pkg::DUTY_MAX
                                                       : quo_in[pfbd_pkg::DUTY_W-1:0];
               state_in = ST_EMIT;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_det_in   = held_det_ff;
               rsp_duty_in  = held_duty_ff;
               rsp_tally_in = held_tally_ff;
               rsp_done_in  = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         held_det_ff   <= 1'b0;
         held_duty_ff  <= '0;
         held_tally_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         held_det_ff   <= held_det_in;
         held_duty_ff  <= held_duty_in;
         held_tally_ff <= held_tally_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      rem_ff       <= rem_in;
      dvs_ff       <= dvs_in;
      quo_ff       <= quo_in;
      step_ff      <= step_in;
      rsp_det_ff   <= rsp_det_in;
      rsp_duty_ff  <= rsp_duty_in;
      rsp_tally_ff <= rsp_tally_in;
      rsp_done_ff  <= rsp_done_in;
   end

   assign rsp.valid             = rsp_valid_ff;
   assign rsp.detected          = rsp_det_ff;
   assign rsp.duty_percent      = rsp_duty_ff;
   assign rsp.window_edge_count = rsp_tally_ff;
   assign rsp.window_done       = rsp_done_ff;

   `PFBD_ASSERT_IMP(a_step_range, clock, reset, state_ff == ST_DIV,
                    step_ff <= pfbd_pkg::DIV_LAST_STEP)
   `PFBD_ASSERT_IMP(a_emit_detected, clock, reset, state_ff == ST_EMIT, held_det_ff)
   `PFBD_ASSERT_NXT(a_div_start, clock, reset,
                    q_pop && q_head.close && q_head.hit, state_ff == ST_DIV)

endmodule
